// ===== sv/eop_pkg.sv =====
// shared types and constants for the evenodd parity encoder
package eop_pkg;

   localparam int K_W         = 5;
   localparam int SYM_W       = 32;
   localparam int ROW_OUT_W   = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QCNT_W      = 2;
   localparam int K_MIN       = 3;
   localparam int K_RESET     = 5;

   localparam logic KIND_P = 1'b0;
   localparam logic KIND_Q = 1'b1;

   typedef struct packed {
      logic [SYM_W-1:0] sym;
      logic [K_W-1:0]   diag;
      logic [K_W-1:0]   row;
      logic             row_end;
      logic             last;
   } item_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ACC   = 6'b000010,
      ST_RDADJ = 6'b000100,
      ST_ADJ   = 6'b001000,
      ST_RD    = 6'b010000,
      ST_LOAD  = 6'b100000
   } state_type;

endpackage

// ===== sv/eop_front.sv =====
// front end: accepts symbols, tracks row, column and diagonal of each item
module eop_front #(
   parameter int SYMBOL_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      flush,
   input  logic [eop_pkg::K_W-1:0]   k_eff,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [eop_pkg::SYM_W-1:0] req_symbol,
   output logic                      push_valid,
   output eop_pkg::item_type         push_item,
   input  logic                      push_ready
);

   localparam logic [63:0] FULL_MASK = (SYMBOL_BITS >= 64) ? {64{1'b1}} :
                                       ((64'd1 << SYMBOL_BITS) - 64'd1);
   localparam logic [eop_pkg::SYM_W-1:0] SYM_MASK = FULL_MASK[eop_pkg::SYM_W-1:0];

   logic [eop_pkg::K_W-1:0] col_ff, col_in;
   logic [eop_pkg::K_W-1:0] row_ff, row_in;
   logic [eop_pkg::K_W-1:0] diag_ff, diag_in;
   logic [eop_pkg::K_W-1:0] k_m1;
   logic [eop_pkg::K_W-1:0] k_m2;
   logic                    row_end;
   logic                    last;
   logic                    accept;

   assign k_m1    = k_eff - eop_pkg::K_W'(1);
   assign k_m2    = k_eff - eop_pkg::K_W'(2);
   assign row_end = (col_ff == k_m1);
   assign last    = row_end && (row_ff == k_m2);

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   assign push_item.sym     = req_symbol & SYM_MASK;
   assign push_item.diag    = diag_ff;
   assign push_item.row     = row_ff;
   assign push_item.row_end = row_end;
   assign push_item.last    = last;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      diag_in = diag_ff;
      if (accept) begin
         if (last) begin
            col_in  = '0;
            row_in  = '0;
            diag_in = '0;
         end else if (row_end) begin
            col_in  = '0;
            row_in  = row_ff + eop_pkg::K_W'(1);
            diag_in = row_ff + eop_pkg::K_W'(1);
         end else begin
            col_in  = col_ff + eop_pkg::K_W'(1);
            diag_in = (diag_ff == k_m1) ? '0 : diag_ff + eop_pkg::K_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         col_ff  <= '0;
         row_ff  <= '0;
         diag_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         diag_ff <= diag_in;
      end
   end

endmodule

// ===== sv/eop_queue.sv =====
// two-entry item queue between front end and back end
module eop_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              flush,
   input  logic              push_valid,
   input  eop_pkg::item_type push_item,
   output logic              push_ready,
   output logic              pop_valid,
   output eop_pkg::item_type pop_item,
   input  logic              pop_ready
);

   eop_pkg::item_type          q_ff [eop_pkg::QUEUE_DEPTH];
   logic                       wr_ptr_ff;
   logic                       rd_ptr_ff;
   logic [eop_pkg::QCNT_W-1:0] cnt_ff;
   logic                       do_push;
   logic                       do_pop;

   assign push_ready = (cnt_ff != eop_pkg::QCNT_W'(eop_pkg::QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = q_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + eop_pkg::QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - eop_pkg::QCNT_W'(1);
         end
      end
   end

endmodule

// ===== sv/eop_back.sv =====
// back end: row and diagonal accumulation, parity burst and result register
module eop_back #(
   parameter int MAX_K = 17
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          flush,
   input  logic [eop_pkg::K_W-1:0]       k_eff,
   input  logic                          pop_valid,
   input  eop_pkg::item_type             pop_item,
   output logic                          pop_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_parity_kind,
   output logic [eop_pkg::ROW_OUT_W-1:0] rsp_parity_row,
   output logic [eop_pkg::SYM_W-1:0]     rsp_parity_value,
   output logic                          rsp_last_of_stripe
);

   localparam int DW = $clog2(MAX_K);
   localparam int RW = $clog2(MAX_K - 1);

   eop_pkg::state_type state_ff, state_in;

   logic [eop_pkg::SYM_W-1:0] diag_mem [MAX_K];
   logic [eop_pkg::SYM_W-1:0] row_mem [MAX_K-1];
   logic [MAX_K-1:0]          dvalid_ff;

   eop_pkg::item_type         cur_ff;
   logic [eop_pkg::SYM_W-1:0] row_acc_ff;
   logic [eop_pkg::SYM_W-1:0] adj_ff;
   logic [eop_pkg::K_W-1:0]   idx_ff;
   logic                      kind_ff;
   logic [eop_pkg::SYM_W-1:0] drd_ff;
   logic                      dhit_ff;
   logic [eop_pkg::SYM_W-1:0] rrd_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_kind_ff;
   logic [eop_pkg::ROW_OUT_W-1:0] rsp_row_ff;
   logic [eop_pkg::SYM_W-1:0]     rsp_value_ff;
   logic                          rsp_last_ff;

   logic [eop_pkg::K_W-1:0]   d_raddr;
   logic [eop_pkg::K_W-1:0]   k_m1;
   logic [eop_pkg::K_W-1:0]   k_m2;
   logic [eop_pkg::SYM_W-1:0] dval;
   logic [eop_pkg::SYM_W-1:0] row_sum;
   logic                      rsp_load;
   logic                      end_idx;
   logic                      stripe_done;

   assign k_m1        = k_eff - eop_pkg::K_W'(1);
   assign k_m2        = k_eff - eop_pkg::K_W'(2);
   assign dval        = dhit_ff ? drd_ff : '0;
   assign row_sum     = row_acc_ff ^ cur_ff.sym;
   assign pop_ready   = (state_ff == eop_pkg::ST_IDLE);
   assign rsp_load    = (state_ff == eop_pkg::ST_LOAD) && (!rsp_valid_ff || rsp_ready);
   assign end_idx     = (idx_ff == k_m2);
   assign stripe_done = rsp_load && end_idx && (kind_ff == eop_pkg::KIND_Q);

   always_comb begin
      case (state_ff)
         eop_pkg::ST_IDLE:  d_raddr = pop_item.diag;
         eop_pkg::ST_RDADJ: d_raddr = k_m1;
         default:           d_raddr = idx_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         eop_pkg::ST_IDLE: begin
            if (pop_valid) state_in = eop_pkg::ST_ACC;
         end
         eop_pkg::ST_ACC: begin
            state_in = cur_ff.last ? eop_pkg::ST_RDADJ : eop_pkg::ST_IDLE;
         end
         eop_pkg::ST_RDADJ: state_in = eop_pkg::ST_ADJ;
         eop_pkg::ST_ADJ:   state_in = eop_pkg::ST_RD;
         eop_pkg::ST_RD:    state_in = eop_pkg::ST_LOAD;
         eop_pkg::ST_LOAD: begin
            if (rsp_load) begin
               state_in = stripe_done ? eop_pkg::ST_IDLE : eop_pkg::ST_RD;
            end
         end
         default: state_in = eop_pkg::ST_IDLE;
      endcase
   end

   // memory ports
   always_ff @(posedge clock) begin
      drd_ff  <= diag_mem[d_raddr[DW-1:0]];
      dhit_ff <= dvalid_ff[d_raddr[DW-1:0]];
      rrd_ff  <= row_mem[idx_ff[RW-1:0]];
      if (state_ff == eop_pkg::ST_ACC) begin
         diag_mem[cur_ff.diag[DW-1:0]] <= dval ^ cur_ff.sym;
         if (cur_ff.row_end) begin
            row_mem[cur_ff.row[RW-1:0]] <= row_sum;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if ((state_ff == eop_pkg::ST_IDLE) && pop_valid) begin
         cur_ff <= pop_item;
      end
      if (state_ff == eop_pkg::ST_ADJ) begin
         adj_ff <= dval;
      end
      if (rsp_load) begin
         rsp_kind_ff  <= kind_ff;
         rsp_row_ff   <= idx_ff[eop_pkg::ROW_OUT_W-1:0];
         rsp_value_ff <= (kind_ff == eop_pkg::KIND_Q) ? (dval ^ adj_ff) : rrd_ff;
         rsp_last_ff  <= (kind_ff == eop_pkg::KIND_Q) && end_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         state_ff     <= eop_pkg::ST_IDLE;
         dvalid_ff    <= '0;
         row_acc_ff   <= '0;
         idx_ff       <= '0;
         kind_ff      <= eop_pkg::KIND_P;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == eop_pkg::ST_ACC) begin
            dvalid_ff[cur_ff.diag[DW-1:0]] <= 1'b1;
            row_acc_ff <= cur_ff.row_end ? '0 : row_sum;
         end
         if (state_ff == eop_pkg::ST_ADJ) begin
            idx_ff  <= '0;
            kind_ff <= eop_pkg::KIND_P;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            if (end_idx) begin
               idx_ff  <= '0;
               kind_ff <= eop_pkg::KIND_Q;
            end else begin
               idx_ff <= idx_ff + eop_pkg::K_W'(1);
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (stripe_done) begin
            dvalid_ff <= '0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_parity_kind    = rsp_kind_ff;
   assign rsp_parity_row     = rsp_row_ff;
   assign rsp_parity_value   = rsp_value_ff;
   assign rsp_last_of_stripe = rsp_last_ff;

endmodule

// ===== sv/evenodd_parity_encoder.sv =====
// evenodd parity encoder top level: column count register, front end, queue, back end
// back end: each symbol is a diagonal memory read (ST_IDLE), then a write back (ST_ACC)
// the parity burst runs ST_RDADJ and ST_ADJ once, then ST_RD and ST_LOAD per parity symbol
// a stripe holds k(k-1) symbols
// first result: last symbol passes the queue, ST_ACC, ST_RDADJ, ST_ADJ, ST_RD, then ST_LOAD
// synchronous reset clears counters, queue and valid bits; column count resets to 5
module evenodd_parity_encoder #(
   parameter int MAX_K       = 17,
   parameter int SYMBOL_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [eop_pkg::K_W-1:0]       csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [eop_pkg::SYM_W-1:0]     req_symbol,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_parity_kind,
   output logic [eop_pkg::ROW_OUT_W-1:0] rsp_parity_row,
   output logic [eop_pkg::SYM_W-1:0]     rsp_parity_value,
   output logic                          rsp_last_of_stripe
);

   logic [eop_pkg::K_W-1:0] k_ff, k_in;
   logic                    push_valid;
   logic                    push_ready;
   eop_pkg::item_type       push_item;
   logic                    pop_valid;
   logic                    pop_ready;
   eop_pkg::item_type       pop_item;

   // clamp column count into the supported range
   always_comb begin
      if (csr_wr_data < eop_pkg::K_W'(eop_pkg::K_MIN)) begin
         k_in = eop_pkg::K_W'(eop_pkg::K_MIN);
      end else if (csr_wr_data > eop_pkg::K_W'(MAX_K)) begin
         k_in = eop_pkg::K_W'(MAX_K);
      end else begin
         k_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= eop_pkg::K_W'(eop_pkg::K_RESET);
      end else if (csr_wr_en) begin
         k_ff <= k_in;
      end
   end

   eop_front #(
      .SYMBOL_BITS(SYMBOL_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .flush      (csr_wr_en),
      .k_eff      (k_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_symbol (req_symbol),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   eop_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .flush      (csr_wr_en),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready)
   );

   eop_back #(
      .MAX_K(MAX_K)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .flush              (csr_wr_en),
      .k_eff              (k_ff),
      .pop_valid          (pop_valid),
      .pop_item           (pop_item),
      .pop_ready          (pop_ready),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_parity_kind    (rsp_parity_kind),
      .rsp_parity_row     (rsp_parity_row),
      .rsp_parity_value   (rsp_parity_value),
      .rsp_last_of_stripe (rsp_last_of_stripe)
   );

endmodule
